/* hw/rtl/slps_pkg.sv */
package slps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 64;

    // sign-magnitude working value
    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } t_sm;

    // commands
    localparam logic [2:0] CMD_TARGET  = 3'd0;
    localparam logic [2:0] CMD_END     = 3'd4;
    localparam logic [2:0] CMD_COMPUTE = 3'd5;

    // microcode op kinds
    localparam logic [2:0] K_DOT    = 3'd0;
    localparam logic [2:0] K_MULDIV = 3'd1;
    localparam logic [2:0] K_ISQRT  = 3'd2;
    localparam logic [2:0] K_ADD    = 3'd3;
    localparam logic [2:0] K_SUB    = 3'd4;
    localparam logic [2:0] K_MAX    = 3'd5;
    localparam logic [2:0] K_CHECK  = 3'd6;
    localparam logic [2:0] K_END    = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [4:0] dst;
        logic       neg;
    } t_op;

    // scratch entries
    localparam logic [4:0] SC_TL   = 5'd0;
    localparam logic [4:0] SC_RL   = 5'd1;
    localparam logic [4:0] SC_UL   = 5'd2;
    localparam logic [4:0] SC_D    = 5'd3;
    localparam logic [4:0] SC_N0   = 5'd4;
    localparam logic [4:0] SC_TMP  = 5'd7;
    localparam logic [4:0] SC_ZN   = 5'd8;
    localparam logic [4:0] SC_ZF   = 5'd9;
    localparam logic [4:0] SC_SUM  = 5'd10;
    localparam logic [4:0] SC_ZS   = 5'd11;
    localparam logic [4:0] SC_K    = 5'd12;
    localparam logic [4:0] SC_VDT  = 5'd13;
    localparam logic [4:0] SC_Q    = 5'd14;
    localparam logic [4:0] SC_OFS  = 5'd15;
    localparam logic [4:0] SC_T1   = 5'd16;
    localparam logic [4:0] SC_T2   = 5'd17;
    localparam logic [4:0] SC_R00  = 5'd18;
    localparam logic [4:0] SC_R10  = 5'd21;
    localparam logic [4:0] SC_R20  = 5'd24;
    localparam logic [4:0] SC_FALL = 5'd28;
    localparam int         SC_NUM  = 29;

    // operand space
    localparam logic [5:0] OP_VT   = 6'd0;
    localparam logic [5:0] OP_VR   = 6'd3;
    localparam logic [5:0] OP_VU   = 6'd6;
    localparam logic [5:0] OP_VS   = 6'd9;
    localparam logic [5:0] OP_VE   = 6'd12;
    localparam logic [5:0] OP_NVEC = 6'd15;
    localparam logic [5:0] OP_SC   = 6'd16;
    localparam logic [5:0] OP_ONE  = 6'd48;
    localparam logic [5:0] OP_UNIT = 6'd49;
    localparam logic [5:0] OP_P31  = 6'd50;
    localparam logic [5:0] OP_HALF = 6'd51;
    localparam logic [5:0] OP_C8   = 6'd52;
    localparam logic [5:0] OP_C16  = 6'd53;

    localparam logic [MAG_BITS-1:0] V_ONE  = 64'd1 << FRAC_BITS;
    localparam logic [MAG_BITS-1:0] V_P31  = 64'd1 << (2 * FRAC_BITS - 1);
    localparam logic [MAG_BITS-1:0] V_HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [MAG_BITS-1:0] V_C8   = 64'd8 << FRAC_BITS;
    localparam logic [MAG_BITS-1:0] V_C16  = 64'd16 << FRAC_BITS;
    localparam logic [MAG_BITS-1:0] MAG_CAP = 64'd1 << 61;

    function automatic logic [5:0] sc(input logic [4:0] idx);
        return OP_SC + {1'b0, idx};
    endfunction

    function automatic t_op mk(input logic [2:0] kind, input logic [5:0] a,
                               input logic [5:0] b, input logic [5:0] c,
                               input logic [4:0] dst, input logic neg);
        t_op o;
        o.kind = kind;
        o.a    = a;
        o.b    = b;
        o.c    = c;
        o.dst  = dst;
        o.neg  = neg;
        return o;
    endfunction

    // compute program
    function automatic t_op prog(input logic [5:0] pc);
        t_op o;
        case (pc)
            6'd0:  o = mk(K_DOT, OP_VT, OP_VT, 6'd0, SC_TL, 1'b0);
            6'd1:  o = mk(K_DOT, OP_VR, OP_VR, 6'd0, SC_RL, 1'b0);
            6'd2:  o = mk(K_DOT, OP_VU, OP_VU, 6'd0, SC_UL, 1'b0);
            6'd3:  o = mk(K_CHECK, 6'd0, 6'd0, 6'd0, 5'd0, 1'b0);
            6'd4:  o = mk(K_ISQRT, sc(SC_TL), 6'd0, 6'd0, SC_D, 1'b0);
            6'd5:  o = mk(K_MULDIV, OP_VT, OP_ONE, sc(SC_D), SC_N0, 1'b0);
            6'd6:  o = mk(K_MULDIV, OP_VT + 6'd1, OP_ONE, sc(SC_D), SC_N0 + 5'd1, 1'b0);
            6'd7:  o = mk(K_MULDIV, OP_VT + 6'd2, OP_ONE, sc(SC_D), SC_N0 + 5'd2, 1'b0);
            6'd8:  o = mk(K_DOT, OP_VS, sc(SC_N0), 6'd0, SC_TMP, 1'b0);
            6'd9:  o = mk(K_MULDIV, sc(SC_TMP), OP_UNIT, OP_ONE, SC_TMP, 1'b0);
            6'd10: o = mk(K_MAX, sc(SC_TMP), OP_C8, 6'd0, SC_ZN, 1'b0);
            6'd11: o = mk(K_DOT, OP_VE, sc(SC_N0), 6'd0, SC_TMP, 1'b0);
            6'd12: o = mk(K_MULDIV, sc(SC_TMP), OP_UNIT, OP_ONE, SC_TMP, 1'b0);
            6'd13: o = mk(K_MAX, sc(SC_TMP), OP_C16, 6'd0, SC_ZF, 1'b0);
            6'd14: o = mk(K_ADD, sc(SC_ZN), sc(SC_ZF), 6'd0, SC_SUM, 1'b0);
            6'd15: o = mk(K_MULDIV, sc(SC_SUM), OP_ONE, sc(SC_ZF), SC_ZS, 1'b0);
            6'd16: o = mk(K_MULDIV, sc(SC_N0), sc(SC_ZS), OP_ONE, SC_R20, 1'b0);
            6'd17: o = mk(K_MULDIV, sc(SC_N0 + 5'd1), sc(SC_ZS), OP_ONE, SC_R20 + 5'd1, 1'b0);
            6'd18: o = mk(K_MULDIV, sc(SC_N0 + 5'd2), sc(SC_ZS), OP_ONE, SC_R20 + 5'd2, 1'b0);
            6'd19: o = mk(K_MULDIV, sc(SC_ZN), sc(SC_ZS), OP_ONE, SC_R20 + 5'd3, 1'b1);
            6'd20: o = mk(K_MULDIV, sc(SC_D), OP_P31, sc(SC_RL), SC_K, 1'b0);
            6'd21: o = mk(K_DOT, OP_VR, OP_VT, 6'd0, SC_VDT, 1'b0);
            6'd22: o = mk(K_MULDIV, sc(SC_VDT), OP_HALF, sc(SC_RL), SC_Q, 1'b0);
            6'd23: o = mk(K_SUB, OP_HALF, sc(SC_Q), 6'd0, SC_OFS, 1'b0);
            6'd24: o = mk(K_MULDIV, OP_VR, sc(SC_K), OP_ONE, SC_T1, 1'b0);
            6'd25: o = mk(K_MULDIV, sc(SC_OFS), sc(SC_N0), OP_ONE, SC_T2, 1'b0);
            6'd26: o = mk(K_ADD, sc(SC_T1), sc(SC_T2), 6'd0, SC_R00, 1'b0);
            6'd27: o = mk(K_MULDIV, OP_VR + 6'd1, sc(SC_K), OP_ONE, SC_T1, 1'b0);
            6'd28: o = mk(K_MULDIV, sc(SC_OFS), sc(SC_N0 + 5'd1), OP_ONE, SC_T2, 1'b0);
            6'd29: o = mk(K_ADD, sc(SC_T1), sc(SC_T2), 6'd0, SC_R00 + 5'd1, 1'b0);
            6'd30: o = mk(K_MULDIV, OP_VR + 6'd2, sc(SC_K), OP_ONE, SC_T1, 1'b0);
            6'd31: o = mk(K_MULDIV, sc(SC_OFS), sc(SC_N0 + 5'd2), OP_ONE, SC_T2, 1'b0);
            6'd32: o = mk(K_ADD, sc(SC_T1), sc(SC_T2), 6'd0, SC_R00 + 5'd2, 1'b0);
            6'd33: o = mk(K_MULDIV, sc(SC_D), OP_P31, sc(SC_UL), SC_K, 1'b1);
            6'd34: o = mk(K_DOT, OP_VU, OP_VT, 6'd0, SC_VDT, 1'b0);
            6'd35: o = mk(K_MULDIV, sc(SC_VDT), OP_HALF, sc(SC_UL), SC_Q, 1'b0);
            6'd36: o = mk(K_ADD, OP_HALF, sc(SC_Q), 6'd0, SC_OFS, 1'b0);
            6'd37: o = mk(K_MULDIV, OP_VU, sc(SC_K), OP_ONE, SC_T1, 1'b0);
            6'd38: o = mk(K_MULDIV, sc(SC_OFS), sc(SC_N0), OP_ONE, SC_T2, 1'b0);
            6'd39: o = mk(K_ADD, sc(SC_T1), sc(SC_T2), 6'd0, SC_R10, 1'b0);
            6'd40: o = mk(K_MULDIV, OP_VU + 6'd1, sc(SC_K), OP_ONE, SC_T1, 1'b0);
            6'd41: o = mk(K_MULDIV, sc(SC_OFS), sc(SC_N0 + 5'd1), OP_ONE, SC_T2, 1'b0);
            6'd42: o = mk(K_ADD, sc(SC_T1), sc(SC_T2), 6'd0, SC_R10 + 5'd1, 1'b0);
            6'd43: o = mk(K_MULDIV, OP_VU + 6'd2, sc(SC_K), OP_ONE, SC_T1, 1'b0);
            6'd44: o = mk(K_MULDIV, sc(SC_OFS), sc(SC_N0 + 5'd2), OP_ONE, SC_T2, 1'b0);
            6'd45: o = mk(K_ADD, sc(SC_T1), sc(SC_T2), 6'd0, SC_R10 + 5'd2, 1'b0);
            6'd46: o = mk(K_MULDIV, OP_ONE, OP_ONE, sc(SC_SUM), SC_FALL, 1'b0);
            default: o = mk(K_END, 6'd0, 6'd0, 6'd0, 5'd0, 1'b0);
        endcase
        return o;
    endfunction

endpackage

/* hw/rtl/spot_light_projection_setup_core.sv */
// Spot-light texture projection matrix setup.
//
// Input channel (i_valid / o_ready): one request carries a command and a
// signed Q16.16 3-vector. Commands target, right, up, start and end store
// the vector and produce no result. The compute command runs
// the setup program and then emits four results, rows 0 to 3 in order,
// each with the falloff reciprocal, the bad-vector flag and last_row on row 3.
// Codes 6 and 7 are dropped.
//
// Output channel (o_valid / i_ready): a single output register. A stalled
// receiver holds the current row; the sequencer waits in its emit state.
// After row 3 is loaded the block takes new requests again.
//
// Loads leave the block ready for the next request. A compute keeps o_ready
// low until row 3 is emitted; its time is set by the shared 128-step
// restoring divider used by nine of the 27 multiply-divide steps (divisions
// by one unit are a plain shift), plus a 32-step square root.
//
// Reset (synchronous, active low) clears the stored vectors to zero and
// returns the sequencer to idle with no result pending.
module spot_light_projection_setup_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col_a,
    output logic signed [31:0] o_col_b,
    output logic signed [31:0] o_col_c,
    output logic signed [31:0] o_col_d,
    output logic signed [31:0] o_falloff_scale,
    output logic               o_bad_vector,
    output logic               o_last_row
);
    import slps_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_LDA   = 4'd2;
    localparam logic [3:0] ST_LDB   = 4'd3;
    localparam logic [3:0] ST_LDC   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_DIVS  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_ISQ   = 4'd9;
    localparam logic [3:0] ST_DOTM  = 4'd10;
    localparam logic [3:0] ST_DOTA  = 4'd11;
    localparam logic [3:0] ST_DOTF  = 4'd12;
    localparam logic [3:0] ST_ALU   = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    // control
    logic [3:0] r_state;
    logic [5:0] r_pc;
    logic [1:0] r_j;
    logic [6:0] r_cnt;
    logic [2:0] r_k;
    logic [1:0] r_row;
    logic       r_bad;
    logic       r_cap;
    logic       r_out_valid;

    // storage
    logic [WORD_BITS-1:0] r_vec [0:14];
    t_sm                  r_sc  [0:SC_NUM-1];

    // shared unit
    t_sm           r_opa, r_opb, r_opc;
    logic [63:0]   r_pp;
    logic [127:0]  r_prod;
    logic [63:0]   r_rem;
    logic [63:0]   r_pos, r_ng;
    logic [63:0]   r_sq_n, r_sq_res, r_sq_bit;

    // output register
    logic [1:0]  r_o_row;
    logic [31:0] r_o_a, r_o_b, r_o_c, r_o_d, r_o_fall;
    logic        r_o_bad;

    t_op         w_op;
    logic [5:0]  rd_sel;
    t_sm         rd_val;
    logic [4:0]  rd_sc;
    logic [3:0]  vbase;

    assign w_op    = prog(r_pc);
    assign o_ready = (r_state == ST_IDLE);
    assign vbase   = 4'(i_command) * 4'd3;

    function automatic t_sm vec_sm(input logic [WORD_BITS-1:0] x);
        t_sm         s;
        logic [63:0] se;
        se    = {{(64 - WORD_BITS){x[WORD_BITS-1]}}, x};
        s.neg = x[WORD_BITS-1];
        s.mag = s.neg ? (64'd0 - se) : se;
        return s;
    endfunction

    function automatic t_sm sm_add(input t_sm a, input t_sm b);
        t_sm s;
        if (a.neg == b.neg) begin
            s.neg = a.neg;
            s.mag = a.mag + b.mag;
        end else if (a.mag >= b.mag) begin
            s.neg = a.neg;
            s.mag = a.mag - b.mag;
        end else begin
            s.neg = b.neg;
            s.mag = b.mag - a.mag;
        end
        return s;
    endfunction

    function automatic logic [31:0] out_word(input t_sm v);
        logic [31:0] w;
        if (v.neg) begin
            w = (v.mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - v.mag[31:0]);
        end else begin
            w = (v.mag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v.mag[31:0];
        end
        return w;
    endfunction

    // single operand read port
    always_comb begin
        case (r_state)
            ST_LDA:  rd_sel = w_op.a + {4'd0, r_j};
            ST_LDB:  rd_sel = w_op.b + {4'd0, r_j};
            ST_LDC:  rd_sel = w_op.c;
            default: rd_sel = w_op.a;
        endcase
    end

    assign rd_sc = 5'(rd_sel - OP_SC);

    always_comb begin
        rd_val = '0;
        if (rd_sel < OP_NVEC) begin
            rd_val = vec_sm(r_vec[rd_sel[3:0]]);
        end else if (rd_sel >= OP_SC && rd_sel < OP_SC + 6'(SC_NUM)) begin
            rd_val = r_sc[rd_sc];
        end else begin
            case (rd_sel)
                OP_ONE:  rd_val.mag = V_ONE;
                OP_UNIT: rd_val.mag = 64'd1;
                OP_P31:  rd_val.mag = V_P31;
                OP_HALF: rd_val.mag = V_HALF;
                OP_C8:   rd_val.mag = V_C8;
                OP_C16:  rd_val.mag = V_C16;
                default: rd_val.mag = 64'd0;
            endcase
        end
    end

    // shared 32x32 multiplier
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [127:0] pp_shift;
    always_comb begin
        mul_a = r_opa.mag[31:0];
        mul_b = r_opb.mag[31:0];
        if (r_state == ST_MUL) begin
            case (r_k[2:1])
                2'd0: begin mul_a = r_opa.mag[31:0];  mul_b = r_opb.mag[31:0];  end
                2'd1: begin mul_a = r_opa.mag[31:0];  mul_b = r_opb.mag[63:32]; end
                2'd2: begin mul_a = r_opa.mag[63:32]; mul_b = r_opb.mag[31:0];  end
                default: begin mul_a = r_opa.mag[63:32]; mul_b = r_opb.mag[63:32]; end
            endcase
        end
        case (r_k[2:1])
            2'd0:    pp_shift = {64'd0, r_pp};
            2'd3:    pp_shift = {r_pp, 64'd0};
            default: pp_shift = {32'd0, r_pp, 32'd0};
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider step
    logic [64:0] dv_sh;
    logic        dv_ge;
    assign dv_sh = {r_rem, r_prod[127]};
    assign dv_ge = dv_sh >= {1'b0, r_opc.mag};

    // rounding and saturation
    logic        fn_rnd, fn_over;
    logic [62:0] fn_sum;
    logic [63:0] fn_mag;
    assign fn_rnd  = {r_rem, 1'b0} >= {1'b0, r_opc.mag};
    assign fn_sum  = {1'b0, r_prod[61:0]} + 63'(fn_rnd);
    assign fn_over = r_cap || (r_prod[127:62] != '0) || (fn_sum > 63'(MAG_CAP));
    assign fn_mag  = fn_over ? MAG_CAP : {1'b0, fn_sum};

    // square root step
    logic [63:0] n_sq_sum, n_sq_n, n_sq_res;
    always_comb begin
        n_sq_sum = r_sq_res + r_sq_bit;
        if (r_sq_n >= n_sq_sum) begin
            n_sq_n   = r_sq_n - n_sq_sum;
            n_sq_res = (r_sq_res >> 1) + r_sq_bit;
        end else begin
            n_sq_n   = r_sq_n;
            n_sq_res = r_sq_res >> 1;
        end
    end

    // add / subtract / clamp
    t_sm alu_b, alu_res;
    always_comb begin
        alu_b = r_opb;
        if (w_op.kind == K_SUB) begin
            alu_b.neg = ~r_opb.neg;
        end
        if (w_op.kind == K_MAX) begin
            alu_res = (!r_opa.neg && r_opa.mag > r_opb.mag) ? r_opa : r_opb;
        end else begin
            alu_res = sm_add(r_opa, alu_b);
        end
    end

    // dot accumulate
    logic [63:0] n_pos, n_ng;
    always_comb begin
        n_pos = r_pos;
        n_ng  = r_ng;
        if (r_opa.neg ^ r_opb.neg) begin
            n_ng = r_ng + r_pp;
        end else begin
            n_pos = r_pos + r_pp;
        end
    end

    // row selection for emit
    t_sm em0, em1, em2, em3;
    always_comb begin
        em3 = '0;
        case (r_row)
            2'd0: begin
                em0 = r_sc[SC_R00]; em1 = r_sc[SC_R00 + 5'd1]; em2 = r_sc[SC_R00 + 5'd2];
            end
            2'd1: begin
                em0 = r_sc[SC_R10]; em1 = r_sc[SC_R10 + 5'd1]; em2 = r_sc[SC_R10 + 5'd2];
            end
            2'd2: begin
                em0 = r_sc[SC_R20]; em1 = r_sc[SC_R20 + 5'd1]; em2 = r_sc[SC_R20 + 5'd2];
                em3 = r_sc[SC_R20 + 5'd3];
            end
            default: begin
                em0 = r_sc[SC_N0]; em1 = r_sc[SC_N0 + 5'd1]; em2 = r_sc[SC_N0 + 5'd2];
            end
        endcase
    end

    logic w_emit;
    assign w_emit = (r_state == ST_EMIT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_row       <= '0;
            r_bad       <= 1'b0;
            r_cap       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 15; i++) begin
                r_vec[i] <= '0;
            end
        end else begin
            // output register
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_o_row     <= r_row;
                r_o_bad     <= r_bad;
                r_o_a       <= r_bad ? 32'd0 : out_word(em0);
                r_o_b       <= r_bad ? 32'd0 : out_word(em1);
                r_o_c       <= r_bad ? 32'd0 : out_word(em2);
                r_o_d       <= r_bad ? 32'd0 : out_word(em3);
                r_o_fall    <= r_bad ? 32'd0 : out_word(r_sc[SC_FALL]);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_command <= CMD_END) begin
                            r_vec[vbase]        <= i_vec_x;
                            r_vec[vbase + 4'd1] <= i_vec_y;
                            r_vec[vbase + 4'd2] <= i_vec_z;
                        end else if (i_command == CMD_COMPUTE) begin
                            r_pc    <= '0;
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    r_j   <= '0;
                    r_pos <= '0;
                    r_ng  <= '0;
                    unique case (w_op.kind)
                        K_ISQRT: begin
                            r_sq_n   <= rd_val.mag;
                            r_sq_res <= '0;
                            r_sq_bit <= 64'd1 << 62;
                            r_cnt    <= 7'd31;
                            r_state  <= ST_ISQ;
                        end
                        K_CHECK: begin
                            if (r_sc[SC_TL].mag == '0 || r_sc[SC_RL].mag == '0 ||
                                r_sc[SC_UL].mag == '0) begin
                                r_bad   <= 1'b1;
                                r_row   <= '0;
                                r_state <= ST_EMIT;
                            end else begin
                                r_bad <= 1'b0;
                                r_pc  <= r_pc + 6'd1;
                            end
                        end
                        K_END: begin
                            r_row   <= '0;
                            r_state <= ST_EMIT;
                        end
                        default: r_state <= ST_LDA;
                    endcase
                end
                ST_LDA: begin
                    r_opa   <= rd_val;
                    r_state <= ST_LDB;
                end
                ST_LDB: begin
                    r_opb <= rd_val;
                    if (w_op.kind == K_DOT) begin
                        r_state <= ST_DOTM;
                    end else if (w_op.kind == K_MULDIV) begin
                        r_state <= ST_LDC;
                    end else begin
                        r_state <= ST_ALU;
                    end
                end
                ST_LDC: begin
                    r_opc   <= rd_val;
                    r_k     <= '0;
                    r_prod  <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (!r_k[0]) begin
                        r_pp <= mul_p;
                    end else begin
                        r_prod <= r_prod + pp_shift;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_state <= ST_DIVS;
                    end
                end
                ST_DIVS: begin
                    // zero divisor saturates the result
                    r_cap <= (r_opc.mag == '0);
                    if (r_opc.mag == '0) begin
                        r_state <= ST_FIN;
                    end else if (r_opc.mag == V_ONE) begin
                        // divide by one unit: plain shift
                        r_prod  <= r_prod >> FRAC_BITS;
                        r_rem   <= 64'(r_prod[FRAC_BITS-1:0]);
                        r_state <= ST_FIN;
                    end else begin
                        r_rem   <= '0;
                        r_cnt   <= 7'd127;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= dv_ge ? 64'(dv_sh - {1'b0, r_opc.mag}) : dv_sh[63:0];
                    r_prod <= {r_prod[126:0], dv_ge};
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_sc[w_op.dst] <= '{neg: r_opa.neg ^ r_opb.neg ^ w_op.neg, mag: fn_mag};
                    r_pc           <= r_pc + 6'd1;
                    r_state        <= ST_FETCH;
                end
                ST_ISQ: begin
                    r_sq_n   <= n_sq_n;
                    r_sq_res <= n_sq_res;
                    r_sq_bit <= r_sq_bit >> 2;
                    r_cnt    <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_sc[w_op.dst] <= '{neg: 1'b0, mag: n_sq_res};
                        r_pc           <= r_pc + 6'd1;
                        r_state        <= ST_FETCH;
                    end
                end
                ST_DOTM: begin
                    r_pp    <= mul_p;
                    r_state <= ST_DOTA;
                end
                ST_DOTA: begin
                    r_pos <= n_pos;
                    r_ng  <= n_ng;
                    if (r_j == 2'd2) begin
                        r_state <= ST_DOTF;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= ST_LDA;
                    end
                end
                ST_DOTF: begin
                    if (r_ng > r_pos) begin
                        r_sc[w_op.dst] <= '{neg: 1'b1, mag: r_ng - r_pos};
                    end else begin
                        r_sc[w_op.dst] <= '{neg: 1'b0, mag: r_pos - r_ng};
                    end
                    r_pc    <= r_pc + 6'd1;
                    r_state <= ST_FETCH;
                end
                ST_ALU: begin
                    r_sc[w_op.dst] <= alu_res;
                    r_pc           <= r_pc + 6'd1;
                    r_state        <= ST_FETCH;
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd3) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_row_index     = r_o_row;
    assign o_col_a         = r_o_a;
    assign o_col_b         = r_o_b;
    assign o_col_c         = r_o_c;
    assign o_col_d         = r_o_d;
    assign o_falloff_scale = r_o_fall;
    assign o_bad_vector    = r_o_bad;
    assign o_last_row      = (r_o_row == 2'd3);

    // a bad compute carries all-zero rows
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_vector |-> o_col_a == 0 && o_col_b == 0 && o_col_c == 0 &&
                                   o_col_d == 0 && o_falloff_scale == 0)
        else $error("bad vector row not zero");

    // compute request starts the program at its first step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_command == CMD_COMPUTE |=> r_state == ST_FETCH && r_pc == 0)
        else $error("compute did not start");

    // divider is never entered with a zero divisor
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_opc.mag != '0)
        else $error("divide by zero in iterative divider");

    // emit never overwrites a row the receiver has not taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready && r_state == ST_EMIT |=> $stable(o_row_index))
        else $error("output row overwritten");

endmodule
